// File: hdl/dkpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dkpc_pkg;

	localparam int unsigned CfgW  = 16;
	localparam int unsigned TimeW = 32;
	localparam int unsigned IdxW  = 2;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_STOP   = 2'd1,
		EV_RESUME = 2'd2
	} event_t;

	typedef enum logic [IdxW-1:0] {
		REG_DEBOUNCE    = 2'd0,
		REG_STOP_MAX    = 2'd1,
		REG_RESUME_HOLD = 2'd2
	} reg_idx_t;

	localparam logic [CfgW-1:0] DEBOUNCE_RST    = 16'd20;
	localparam logic [CfgW-1:0] STOP_MAX_RST    = 16'd1000;
	localparam logic [CfgW-1:0] RESUME_HOLD_RST = 16'd3000;

	typedef struct packed {
		logic [CfgW-1:0] debounce_ms;
		logic [CfgW-1:0] stop_max_ms;
		logic [CfgW-1:0] resume_hold_ms;
	} cfg_t;

endpackage

`default_nettype wire

// File: hdl/dkpc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module dkpc_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic                       key,
	input  wire logic [dkpc_pkg::TimeW-1:0] now,
	input  wire dkpc_pkg::cfg_t             cfg,
	output dkpc_pkg::event_t                ev
);
	import dkpc_pkg::*;

	logic              pending_q;
	logic              stable_q;
	logic [TimeW-1:0]  edge_time_q;
	logic              armed_q;
	logic              press_active_q;
	logic [TimeW-1:0]  press_time_q;
	logic              resume_sent_q;

	logic              pending_n;
	logic              stable_n;
	logic [TimeW-1:0]  edge_time_n;
	logic              armed_n;
	logic              press_active_n;
	logic [TimeW-1:0]  press_time_n;
	logic              resume_sent_n;
	logic [TimeW-1:0]  since_edge;
	logic [TimeW-1:0]  held;
	logic              settle;

	always_comb begin
		pending_n      = pending_q;
		edge_time_n    = edge_time_q;
		stable_n       = stable_q;
		armed_n        = armed_q;
		press_active_n = press_active_q;
		press_time_n   = press_time_q;
		resume_sent_n  = resume_sent_q;
		ev             = EV_NONE;

		if (key != pending_q) begin
			pending_n   = key;
			edge_time_n = now;
		end

		since_edge = now - edge_time_n;
		held       = now - press_time_q;
		settle     = (pending_n != stable_q) &&
			(since_edge >= {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms});

		if (settle) begin
			stable_n = pending_n;
			if (!pending_n) begin
				armed_n        = 1'b1;
				press_active_n = 1'b0;
				resume_sent_n  = 1'b0;
				if (press_active_q && !resume_sent_q &&
					held <= {{(TimeW-CfgW){1'b0}}, cfg.stop_max_ms}) begin
					ev = EV_STOP;
				end
			end else if (armed_q) begin
				press_active_n = 1'b1;
				press_time_n   = now;
				resume_sent_n  = 1'b0;
			end
		end else if (press_active_q && !resume_sent_q &&
			held >= {{(TimeW-CfgW){1'b0}}, cfg.resume_hold_ms}) begin
			resume_sent_n = 1'b1;
			ev            = EV_RESUME;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q      <= 1'b0;
			stable_q       <= 1'b0;
			edge_time_q    <= '0;
			armed_q        <= 1'b0;
			press_active_q <= 1'b0;
			press_time_q   <= '0;
			resume_sent_q  <= 1'b0;
		end else if (step) begin
			pending_q      <= pending_n;
			stable_q       <= stable_n;
			edge_time_q    <= edge_time_n;
			armed_q        <= armed_n;
			press_active_q <= press_active_n;
			press_time_q   <= press_time_n;
			resume_sent_q  <= resume_sent_n;
		end
	end

	a_resume_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		resume_sent_q |-> press_active_q)
		else $error("resume flag set without an active press");

	a_press_needs_armed: assert property (@(posedge clk) disable iff (!arst_n)
		press_active_q |-> (armed_q && stable_q))
		else $error("active press while unarmed or released");

	a_resume_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(step && ev == EV_RESUME) |=> resume_sent_q)
		else $error("resume event did not latch its flag");

	a_stop_ends_press: assert property (@(posedge clk) disable iff (!arst_n)
		(step && ev == EV_STOP) |=> (!press_active_q && !stable_q))
		else $error("stop event left press active");

endmodule

`default_nettype wire

// File: hdl/debounced_key_press_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Debounced key press classifier. Each request is one poll (raw key level and
// a wrapping ms time stamp) and returns one event: none, stop (short press
// released within stop_max_ms) or resume (held for resume_hold_ms, once).
// Polls pass through an input register and a result register, one poll per
// clock while out_stall is low; 32-bit subtract-compare paths update the
// debounce/press state. The user must write registers via cfg_we/cfg_index/
// cfg_data only while no request is in flight; the block does not enforce it.
module debounced_key_press_classifier (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       key_pressed,
	input  wire logic [dkpc_pkg::TimeW-1:0] now_ms,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [1:0]                      event_res,
	input  wire logic                       cfg_we,
	input  wire logic [dkpc_pkg::IdxW-1:0]  cfg_index,
	input  wire logic [dkpc_pkg::CfgW-1:0]  cfg_data
);
	import dkpc_pkg::*;

	cfg_t             cfg_q;
	logic             valid_s1;
	logic             key_s1;
	logic [TimeW-1:0] now_s1;
	logic             valid_s2;
	event_t           event_s2;
	event_t           ev;
	logic             advance;

	assign advance   = !(valid_s2 && out_stall);
	assign in_stall  = !advance;
	assign out_valid = valid_s2;
	assign event_res = event_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms    <= DEBOUNCE_RST;
			cfg_q.stop_max_ms    <= STOP_MAX_RST;
			cfg_q.resume_hold_ms <= RESUME_HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:    cfg_q.debounce_ms    <= cfg_data;
				REG_STOP_MAX:    cfg_q.stop_max_ms    <= cfg_data;
				REG_RESUME_HOLD: cfg_q.resume_hold_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_s1   <= key_pressed;
			now_s1   <= now_ms;
			event_s2 <= ev;
		end
	end

	dkpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance && valid_s1),
		.key    (key_s1),
		.now    (now_s1),
		.cfg    (cfg_q),
		.ev     (ev)
	);

endmodule

`default_nettype wire

// File: dv/debounced_key_press_classifier_test.sv
`timescale 1ns / 1ps

module debounced_key_press_classifier_test;
	import dkpc_pkg::*;

	localparam logic [IdxW-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic             key;
		logic [TimeW-1:0] stamp;
	} poll_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             key_pressed = 1'b0;
	logic [TimeW-1:0] now_ms = '0;
	logic             out_valid;
	logic             out_stall = 1'b1;
	logic [1:0]       event_res;
	logic             cfg_we = 1'b0;
	logic [IdxW-1:0]  cfg_index = '0;
	logic [CfgW-1:0]  cfg_data = '0;

	debounced_key_press_classifier u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.key_pressed (key_pressed),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_res   (event_res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state and settings
	logic [CfgW-1:0]  set_debounce = DEBOUNCE_RST;
	logic [CfgW-1:0]  set_stop_max = STOP_MAX_RST;
	logic [CfgW-1:0]  set_resume_hold = RESUME_HOLD_RST;
	logic             kp_pending = 1'b0;
	logic             kp_stable = 1'b0;
	logic [TimeW-1:0] kp_edge = '0;
	logic             kp_armed = 1'b0;
	logic             kp_active = 1'b0;
	logic [TimeW-1:0] kp_press = '0;
	logic             kp_resumed = 1'b0;

	poll_t            polls_pending[$];
	event_t           expected_events[$];
	logic [TimeW-1:0] clock_ms = '0;
	int unsigned      polls_issued = 0;
	int unsigned      polls_taken = 0;
	int unsigned      results_seen = 0;
	int unsigned      stops_seen = 0;
	int unsigned      resumes_seen = 0;
	int unsigned      settings_used = 1;
	int unsigned      faults = 0;
	int unsigned      in_gap = 0;
	int unsigned      out_hold = 0;
	int unsigned      cycle_count = 0;
	bit               calm_in = 1'b0;
	bit               calm_out = 1'b0;

	function automatic event_t classify_poll(input logic key, input logic [TimeW-1:0] stamp);
		event_t           ev;
		logic [TimeW-1:0] held;
		ev = EV_NONE;
		if (key != kp_pending) begin
			kp_pending = key;
			kp_edge = stamp;
		end
		if (kp_pending != kp_stable &&
				TimeW'(stamp - kp_edge) >= TimeW'(set_debounce)) begin
			kp_stable = kp_pending;
			if (!kp_stable) begin
				held = stamp - kp_press;
				if (kp_active && !kp_resumed && held <= TimeW'(set_stop_max))
					ev = EV_STOP;
				kp_armed = 1'b1;
				kp_active = 1'b0;
				kp_resumed = 1'b0;
			end else if (kp_armed) begin
				kp_active = 1'b1;
				kp_press = stamp;
				kp_resumed = 1'b0;
			end
		end else if (kp_active && !kp_resumed &&
				TimeW'(stamp - kp_press) >= TimeW'(set_resume_hold)) begin
			kp_resumed = 1'b1;
			ev = EV_RESUME;
		end
		return ev;
	endfunction

	function automatic int unsigned draw_wait(input bit calm);
		if (calm)
			return 0;
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 18);
			1: return $urandom_range(1, 3);
			default: return 0;
		endcase
	endfunction

	function automatic logic [CfgW-1:0] pick_setting(input int unsigned typical);
		if ($urandom_range(0, 4) == 0)
			return CfgW'($urandom());
		return CfgW'($urandom_range(0, typical));
	endfunction

	always @(posedge clk) begin : poll_driver
		poll_t nxt;
		if (in_valid && !in_stall) begin
			expected_events.push_back(classify_poll(key_pressed, now_ms));
			polls_taken++;
		end
		if (!in_valid || !in_stall) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (polls_pending.size() > 0) begin
				nxt = polls_pending.pop_front();
				in_valid <= 1'b1;
				key_pressed <= nxt.key;
				now_ms <= nxt.stamp;
				in_gap <= draw_wait(calm_in);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : event_monitor
		int unsigned hold;
		event_t      want;
		hold = out_hold;
		if (arst_n && out_valid && !out_stall) begin
			hold = draw_wait(calm_out);
			results_seen++;
			if (expected_events.size() == 0) begin
				faults++;
				$display("%0t: unexpected event, expected none pending, got %0d",
					$time, event_res);
			end else begin
				want = expected_events.pop_front();
				if (want == EV_STOP)
					stops_seen++;
				if (want == EV_RESUME)
					resumes_seen++;
				if (event_res !== want) begin
					faults++;
					$display("%0t: event_res mismatch, expected %0d (%s), got %0d",
						$time, want, want.name(), event_res);
				end
			end
		end
		out_stall <= (hold > 0);
		out_hold <= (hold > 0) ? hold - 1 : 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d requests taken, %0d events pending",
				$time, polls_taken, expected_events.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic push_poll(input logic key, input logic [TimeW-1:0] stamp);
		polls_pending.push_back('{key: key, stamp: stamp});
		polls_issued++;
		clock_ms = stamp;
	endtask

	task automatic drain();
		while (polls_taken != polls_issued || expected_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_DEBOUNCE:    set_debounce = value;
			REG_STOP_MAX:    set_stop_max = value;
			REG_RESUME_HOLD: set_resume_hold = value;
			default: ;
		endcase
	endtask

	task automatic write_settings(input logic [CfgW-1:0] deb, input logic [CfgW-1:0] stop,
			input logic [CfgW-1:0] hold);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_STOP_MAX, stop);
		write_reg(REG_RESUME_HOLD, hold);
		write_reg(REG_UNUSED, CfgW'($urandom()));
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// glitches, tiny steps and jumps anywhere on the time line (also backward)
	task automatic add_noise();
		int unsigned n;
		int unsigned k;
		n = $urandom_range(1, 6);
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 3))
				0: push_poll(1'($urandom_range(0, 1)), $urandom());
				1: push_poll(1'($urandom_range(0, 1)), clock_ms + $urandom_range(0, 3));
				default: push_poll(1'($urandom_range(0, 1)),
					clock_ms + $urandom_range(0, 2 * 32'(set_debounce) + 2));
			endcase
		end
	endtask

	// settle released, bounce in, hold for a chosen span, bounce out, settle
	task automatic add_press_cycle();
		int unsigned      deb;
		int unsigned      stop_lim;
		int unsigned      hold_lim;
		int unsigned      span;
		int unsigned      rel_at;
		int unsigned      at;
		int unsigned      n;
		int unsigned      k;
		logic [TimeW-1:0] base;
		deb = 32'(set_debounce);
		stop_lim = 32'(set_stop_max);
		hold_lim = 32'(set_resume_hold);
		push_poll(1'b0, clock_ms + 1);
		push_poll(1'b0, clock_ms + deb);
		n = 2 * $urandom_range(0, 2);
		for (k = 0; k < n; k++)
			push_poll(~k[0], clock_ms + $urandom_range(0, deb));
		push_poll(1'b1, clock_ms + $urandom_range(1, 5));
		push_poll(1'b1, clock_ms + deb);
		base = clock_ms;
		case ($urandom_range(0, 3))
			0: span = $urandom_range(0, stop_lim);
			1: span = stop_lim + $urandom_range(0, 1);
			2: span = hold_lim + $urandom_range(0, hold_lim / 4 + 2);
			default: span = $urandom_range(0, 2 * hold_lim + 10);
		endcase
		rel_at = (span > deb) ? span - deb : 0;
		at = 0;
		n = $urandom_range(0, 3);
		for (k = 0; k < n; k++) begin
			at = at + $urandom_range(0, (rel_at - at) / 2);
			push_poll(1'b1, base + at);
		end
		if (hold_lim > at && hold_lim <= rel_at && $urandom_range(0, 1)) begin
			push_poll(1'b1, base + hold_lim - 1);
			push_poll(1'b1, base + hold_lim);
		end
		push_poll(1'b0, base + rel_at);
		if ($urandom_range(0, 3) == 0) begin
			push_poll(1'b1, clock_ms + $urandom_range(0, deb));
			push_poll(1'b0, clock_ms + $urandom_range(0, deb));
		end
		push_poll(1'b0, clock_ms + deb);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned stop_at;
		stop_at = polls_issued + count;
		while (polls_issued < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				add_noise();
			else
				add_press_cycle();
		end
	endtask

	initial begin : scenario
		int unsigned ph;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 20 / 1000 / 3000
		push_poll(1'b1, 32'd0);          // stuck pressed from start
		push_poll(1'b1, 32'd30);
		push_poll(1'b1, 32'd5000);       // not armed, no resume
		push_poll(1'b0, 32'd5010);
		push_poll(1'b0, 32'd5030);       // first release arms
		push_poll(1'b1, 32'd5100);
		push_poll(1'b1, 32'd5120);
		push_poll(1'b0, 32'd5300);
		push_poll(1'b0, 32'd5320);       // short press
		push_poll(1'b1, 32'd6000);
		push_poll(1'b1, 32'd6020);
		push_poll(1'b1, 32'd9019);
		push_poll(1'b1, 32'd9020);       // hold reaches resume time
		push_poll(1'b0, 32'd9600);
		push_poll(1'b0, 32'd9620);       // no stop after resume
		push_poll(1'b1, 32'd10000);      // bounce
		push_poll(1'b0, 32'd10005);
		push_poll(1'b1, 32'd10010);
		push_poll(1'b1, 32'd10030);
		push_poll(1'b0, 32'd11010);
		push_poll(1'b0, 32'd11030);      // held exactly stop_max
		push_poll(1'b1, 32'hFFFF_FFF0);  // press across the wrap
		push_poll(1'b1, 32'h0000_0004);
		push_poll(1'b0, 32'h0000_0020);
		push_poll(1'b0, 32'h0000_0034);
		push_poll(1'b1, 32'h0000_0010);  // time going backward
		push_poll(1'b1, 32'h0000_0005);
		push_poll(1'b1, 32'hFFFF_FFFF);
		drain();

		write_settings('0, '0, '0);
		run_random(110);
		drain();

		calm_in = 1'b1;
		write_settings('1, '1, '1);
		run_random(110);
		drain();

		for (ph = 0; ph < 8; ph++) begin
			calm_in = (ph % 3 == 0);
			calm_out = (ph % 3 == 1);
			write_settings(pick_setting(40), pick_setting(1500), pick_setting(4000));
			run_random(150);
			drain();
		end

		$display("covered %0d polls over %0d register settings, %0d events checked",
			polls_taken, settings_used, results_seen);
		$display("short-press stops: %0d, long-hold resumes: %0d, mismatches: %0d",
			stops_seen, resumes_seen, faults);
		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
